[design/tcw_pkg.sv]
// Shared constants for the text console writer: default geometry, cell layout,
// action and register codes, and character codes.
// No dependencies; every other design file imports this package.
package tcw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Cell layout: attribute byte over character byte
  localparam int CELL_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int COLOR_W   = 4;

  // Action codes
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 1'b1;

  // Character codes and reset values
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] RETURN_CHAR  = 8'h0D;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;
  localparam logic [COLOR_W-1:0] RESET_FG = 4'd7;
  localparam logic [COLOR_W-1:0] RESET_BG = 4'd0;

endpackage

[design/tcw_cell_store.sv]
// Screen cell memory: one write port and one read port, read data registered.
// Depends on tcw_pkg for the cell width.
module tcw_cell_store import tcw_pkg::*; #(
  parameter int DEPTH  = DEF_ROWS * DEF_COLUMNS,
  parameter int ADDR_W = $clog2(DEF_ROWS * DEF_COLUMNS)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;

  // Write one cell
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one cell, data valid the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/text_console_writer_unit.sv]
// Text console writer top level: cursor control, scroll and clear sequencing,
// output register. Depends on tcw_pkg and tcw_cell_store.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one request: put character,
//    clear screen or read one cell. Every request gives exactly one result on
//    the output channel (out_valid/out_ready) with the cursor position after
//    the request, the cell read (zero for other actions) and a scroll flag.
//  - Configuration channel (cfg_valid/cfg_ready, always ready) sets the
//    foreground (index 0) and background (index 1) colors; write it only
//    while no request is in flight.
//  - Put, newline, carriage return and out-of-range reads: the result passes the
//    done state into the output register; an in-range read passes the read state first.
//  - Scroll rotates a row offset and blanks one row; clear blanks every cell. Both
//    sweep one cell at a time through the single write port of the cell memory.
//  - One request is worked on at a time; a new request is taken as soon as
//    the previous one has reached the output register, even while that result
//    still waits for out_ready. A stalled result holds until it is taken.
//  - After reset all ROWS*COLUMNS cells (2000 by default) of the cell memory are
//    swept to blank (0x0720), one cell per cycle; in_ready stays low meanwhile.
module text_console_writer_unit import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [7:0]           in_char_code,
  input  logic [4:0]           in_read_row,
  input  logic [6:0]           in_read_col,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [4:0]           out_cursor_row,
  output logic [6:0]           out_cursor_col,
  output logic [CELL_W-1:0]    out_cell_value,
  output logic                 out_scrolled,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_FILL = 5'b00100,
    S_READ = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    top_r, top_nxt;
  logic [COLOR_W-1:0]  fg_r, fg_nxt;
  logic [COLOR_W-1:0]  bg_r, bg_nxt;
  logic [ADDR_W-1:0]   fill_addr_r, fill_addr_nxt;
  logic [ADDR_W-1:0]   fill_last_r, fill_last_nxt;
  logic [CELL_W-1:0]   fill_cell_r, fill_cell_nxt;
  logic                res_scrolled_r, res_scrolled_nxt;
  logic [CELL_W-1:0]   res_cell_r, res_cell_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [4:0]          out_row_r, out_row_nxt;
  logic [6:0]          out_col_r, out_col_nxt;
  logic [CELL_W-1:0]   out_cell_r, out_cell_nxt;
  logic                out_scrolled_r, out_scrolled_nxt;

  logic                in_accept;
  logic [CELL_W-1:0]   blank_cell;
  logic                at_last_row, at_last_col;
  logic [ROW_W-1:0]    top_inc;
  logic [ROW_W-1:0]    cur_phys, rd_phys, rd_row;
  logic [COL_W-1:0]    rd_col;
  logic                rd_in_range;
  logic [ADDR_W-1:0]   cur_addr, rd_addr, top_base;
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [CELL_W-1:0]   wr_data, rd_data;

  // Map a screen row to its memory row through the rotating top offset
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  assign in_accept   = in_valid && in_ready;
  assign in_ready    = (state_r == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign blank_cell  = {bg_r, fg_r, BLANK_CHAR};
  assign at_last_row = (row_r == ROW_W'(ROWS - 1));
  assign at_last_col = (col_r == COL_W'(COLUMNS - 1));
  assign top_inc     = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;

  // Address generation
  assign cur_phys    = phys_row(row_r, top_r);
  assign cur_addr    = ADDR_W'(32'(cur_phys) * COLUMNS + 32'(col_r));
  assign top_base    = ADDR_W'(32'(top_r) * COLUMNS);
  assign rd_in_range = (32'(in_read_row) < ROWS) && (32'(in_read_col) < COLUMNS);
  assign rd_row      = ROW_W'(in_read_row);
  assign rd_col      = COL_W'(in_read_col);
  assign rd_phys     = phys_row(rd_row, top_r);
  assign rd_addr     = ADDR_W'(32'(rd_phys) * COLUMNS + 32'(rd_col));

  // Memory port control: sweeps own the write port, else a put of any character but newline or carriage return
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = {bg_r, fg_r, in_char_code};
    if (state_r == S_INIT || state_r == S_FILL) begin
      wr_en   = 1'b1;
      wr_addr = fill_addr_r;
      wr_data = fill_cell_r;
    end else if (in_accept && in_action == ACT_PUT &&
                 in_char_code != NEWLINE_CHAR && in_char_code != RETURN_CHAR) begin
      wr_en = 1'b1;
    end
  end

  assign rd_en = in_accept && in_action == ACT_READ && rd_in_range;

  tcw_cell_store #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    row_nxt          = row_r;
    col_nxt          = col_r;
    top_nxt          = top_r;
    fg_nxt           = fg_r;
    bg_nxt           = bg_r;
    fill_addr_nxt    = fill_addr_r;
    fill_last_nxt    = fill_last_r;
    fill_cell_nxt    = fill_cell_r;
    res_scrolled_nxt = res_scrolled_r;
    res_cell_nxt     = res_cell_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_row_nxt      = out_row_r;
    out_col_nxt      = out_col_r;
    out_cell_nxt     = out_cell_r;
    out_scrolled_nxt = out_scrolled_r;

    // Take color writes at any time
    if (cfg_valid) begin
      case (cfg_index)
        REG_FG:  fg_nxt = cfg_wdata;
        REG_BG:  bg_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_INIT, S_FILL: begin
        if (fill_addr_r == fill_last_r) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          fill_addr_nxt = fill_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          res_scrolled_nxt = 1'b0;
          res_cell_nxt     = '0;
          state_nxt        = S_DONE;
          case (in_action)
            ACT_PUT: begin
              if (in_char_code == RETURN_CHAR) begin
                col_nxt = '0;
              end else if (in_char_code == NEWLINE_CHAR || at_last_col) begin
                // Move to the next row, scroll past the bottom
                col_nxt = '0;
                if (at_last_row) begin
                  top_nxt          = top_inc;
                  fill_addr_nxt    = top_base;
                  fill_last_nxt    = top_base + ADDR_W'(COLUMNS - 1);
                  fill_cell_nxt    = blank_cell;
                  res_scrolled_nxt = 1'b1;
                  state_nxt        = S_FILL;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
            ACT_CLEAR: begin
              row_nxt       = '0;
              col_nxt       = '0;
              top_nxt       = '0;
              fill_addr_nxt = '0;
              fill_last_nxt = ADDR_W'(CELLS - 1);
              fill_cell_nxt = blank_cell;
              state_nxt     = S_FILL;
            end
            ACT_READ: begin
              if (rd_in_range) begin
                state_nxt = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_cell_nxt = rd_data;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // Load the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_row_nxt      = 5'(row_r);
          out_col_nxt      = 7'(col_r);
          out_cell_nxt     = res_cell_r;
          out_scrolled_nxt = res_scrolled_r;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      fg_r        <= RESET_FG;
      bg_r        <= RESET_BG;
      fill_addr_r <= '0;
      fill_last_r <= ADDR_W'(CELLS - 1);
      fill_cell_r <= {RESET_ATTR, BLANK_CHAR};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_last_r <= fill_last_nxt;
      fill_cell_r <= fill_cell_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    res_scrolled_r <= res_scrolled_nxt;
    res_cell_r     <= res_cell_nxt;
    out_row_r      <= out_row_nxt;
    out_col_r      <= out_col_nxt;
    out_cell_r     <= out_cell_nxt;
    out_scrolled_r <= out_scrolled_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cell_value = out_cell_r;
  assign out_scrolled   = out_scrolled_r;

endmodule

[design/tcw_checker.sv]
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_unit.
module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [4:0]        out_cursor_row,
  input logic [6:0]        out_cursor_col,
  input logic [CELL_W-1:0] out_cell_value,
  input logic              out_scrolled
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_row) &&
      $stable(out_cursor_col) && $stable(out_cell_value) && $stable(out_scrolled))
    else $error("stalled result changed or dropped");

  // Drop ready after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // A scroll leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |->
      out_cursor_col == 7'd0 && out_cursor_row == 5'(ROWS - 1) && out_cell_value == '0)
    else $error("scroll result with wrong cursor or cell");

  // Keep the cursor column on the screen
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_cursor_col) < COLUMNS)
    else $error("cursor column past the row end");

  // Come out of reset with no result pending
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result pending right after reset");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_cursor_row (out_cursor_row),
  .out_cursor_col (out_cursor_col),
  .out_cell_value (out_cell_value),
  .out_scrolled   (out_scrolled)
);

[dv/testbench.sv]
// Self-checking testbench for text_console_writer_unit: random put, clear and read requests
// checked against a shadow of the screen store, the cursor and the colors.
// Depends on tcw_pkg and the text_console_writer_unit RTL only.
module testbench import tcw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 12;
  localparam int NCOLS         = DEF_COLUMNS;
  localparam int NROWS         = DEF_ROWS;
  localparam int NCELLS        = NCOLS * NROWS;
  localparam int MAX_GAP       = 40;
  localparam int PHASE_ITEMS   = 382;
  localparam int SETTLE_CYCLES = 100;
  // A clear sweeps all NCELLS cells. Budget every request as a clear plus the longest
  // gap and stall, then take that several times over.
  localparam int unsigned CYCLE_LIMIT = 12_000_000;

  typedef struct packed {
    logic [4:0]        row;
    logic [6:0]        col;
    logic [CELL_W-1:0] cell_val;
    logic              scrolled;
  } cursor_report_t;

  // Shadow of the console: screen store, cursor, colors and the reports still due
  class console_shadow;
    logic [CELL_W-1:0] screen [NCELLS];
    int unsigned       cur_row, cur_col;
    logic [COLOR_W-1:0] fg, bg;
    cursor_report_t    reports_due[$];
    int unsigned       mismatches, checked, n_reads, n_clears, n_scrolls;

    function new();
      foreach (screen[i]) screen[i] = {RESET_ATTR, BLANK_CHAR};
      cur_row = 0;
      cur_col = 0;
      fg = RESET_FG;
      bg = RESET_BG;
    endfunction

    function void set_color(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
      if (idx == REG_FG) fg = val;
      else if (idx == REG_BG) bg = val;
    endfunction

    function logic [7:0] attr();
      return {bg, fg};
    endfunction

    // Move to the next row; scroll the store up when it runs off the bottom
    function logic next_row();
      cur_row++;
      if (cur_row < NROWS) return 1'b0;
      for (int i = 0; i + NCOLS < NCELLS; i++) screen[i] = screen[i + NCOLS];
      for (int i = NCELLS - NCOLS; i < NCELLS; i++) screen[i] = {attr(), BLANK_CHAR};
      cur_row = NROWS - 1;
      n_scrolls++;
      return 1'b1;
    endfunction

    // Apply one accepted request and queue the report it must produce
    function void note_request(logic [1:0] act, logic [7:0] ch, logic [4:0] rr,
                               logic [6:0] rc);
      cursor_report_t r;
      r = '0;
      case (act)
        ACT_PUT: begin
          if (ch == NEWLINE_CHAR) begin
            cur_col = 0;
            r.scrolled = next_row();
          end else if (ch == RETURN_CHAR) begin
            cur_col = 0;
          end else begin
            screen[cur_row * NCOLS + cur_col] = {attr(), ch};
            cur_col++;
            if (cur_col >= NCOLS) begin
              cur_col = 0;
              r.scrolled = next_row();
            end
          end
        end
        ACT_CLEAR: begin
          foreach (screen[i]) screen[i] = {attr(), BLANK_CHAR};
          cur_row = 0;
          cur_col = 0;
          n_clears++;
        end
        ACT_READ: begin
          if (rr < NROWS && rc < NCOLS) r.cell_val = screen[rr * NCOLS + rc];
          n_reads++;
        end
        default: ;
      endcase
      r.row = cur_row[4:0];
      r.col = cur_col[6:0];
      reports_due.push_back(r);
    endfunction

    function void check_field(string name, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one taken result with the oldest report due
    function void check_result(logic [4:0] row, logic [6:0] col, logic [CELL_W-1:0] cell_val,
                               logic scrolled);
      cursor_report_t want;
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected result: row %0d col %0d cell 0x%0h scrolled %0b",
                 $time, row, col, cell_val, scrolled);
        mismatches++;
        return;
      end
      want = reports_due.pop_front();
      checked++;
      check_field("cursor_row", CELL_W'(want.row), CELL_W'(row));
      check_field("cursor_col", CELL_W'(want.col), CELL_W'(col));
      check_field("cell_value", want.cell_val, cell_val);
      check_field("scrolled", CELL_W'(want.scrolled), CELL_W'(scrolled));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_action;
  logic [7:0]           in_char_code;
  logic [4:0]           in_read_row;
  logic [6:0]           in_read_col;
  logic                 out_valid;
  logic                 out_ready;
  logic [4:0]           out_cursor_row;
  logic [6:0]           out_cursor_col;
  logic [CELL_W-1:0]    out_cell_value;
  logic                 out_scrolled;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_wdata;

  console_shadow sb = new();
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;
  int unsigned   requests_sent = 0;
  int unsigned   color_settings = 0;
  int unsigned   cycle_count = 0;

  text_console_writer_unit dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) out_ready <= ($urandom_range(99) >= receiver_stall_pct);

  // Check every taken result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_cursor_row, out_cursor_col, out_cell_value, out_scrolled);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one request after a random idle gap; hold it until taken
  task automatic send_request(input logic [1:0] act, input logic [7:0] ch,
                              input logic [4:0] rr, input logic [6:0] rc);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_char_code <= ch;
    in_read_row  <= rr;
    in_read_col  <= rc;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, ch, rr, rc);
    requests_sent++;
  endtask

  // Drop valid and hold off until every result due has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.reports_due.size() != 0) @(posedge clk);
  endtask

  // Write both color registers back to back
  task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FG;
    cfg_wdata <= fg;
    do @(posedge clk); while (!cfg_ready);
    sb.set_color(REG_FG, fg);
    cfg_index <= REG_BG;
    cfg_wdata <= bg;
    do @(posedge clk); while (!cfg_ready);
    sb.set_color(REG_BG, bg);
    cfg_valid <= 1'b0;
    color_settings++;
  endtask

  // One random sequence: a text line, a run of newlines, some reads, noise or a clear
  task automatic send_burst();
    int          kind, len;
    logic [7:0]  ch;
    logic [4:0]  rr;
    logic [6:0]  rc;
    kind = $urandom_range(99);
    if (kind < 40) begin
      len = $urandom_range(90);
      repeat (len) begin
        if ($urandom_range(9) == 0) ch = 8'($urandom_range(255));
        else ch = 8'($urandom_range(8'h7E, 8'h20));
        send_request(ACT_PUT, ch, 5'($urandom_range(31)), 7'($urandom_range(127)));
      end
      ch = ($urandom_range(4) == 0) ? RETURN_CHAR : NEWLINE_CHAR;
      send_request(ACT_PUT, ch, 5'($urandom_range(31)), 7'($urandom_range(127)));
    end else if (kind < 55) begin
      len = $urandom_range(30, 1);
      repeat (len)
        send_request(ACT_PUT, NEWLINE_CHAR, 5'($urandom_range(31)), 7'($urandom_range(127)));
    end else if (kind < 85) begin
      len = $urandom_range(6, 1);
      repeat (len) begin
        if ($urandom_range(9) == 0) begin
          rr = 5'($urandom_range(31));
          rc = 7'($urandom_range(127));
        end else begin
          rr = 5'($urandom_range(NROWS - 1));
          rc = 7'($urandom_range(NCOLS - 1));
        end
        send_request(ACT_READ, 8'($urandom_range(255)), rr, rc);
      end
    end else if (kind < 97) begin
      send_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                   5'($urandom_range(31)), 7'($urandom_range(127)));
    end else begin
      send_request(ACT_CLEAR, 8'($urandom_range(255)),
                   5'($urandom_range(31)), 7'($urandom_range(127)));
    end
  endtask

  initial begin
    int unsigned phase_start;
    bit          paused;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= ACT_PUT;
    in_char_code <= '0;
    in_read_row  <= '0;
    in_read_col  <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_FG;
    cfg_wdata    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Wait out the blanking sweep after reset
    while (!in_ready) @(posedge clk);

    // Directed: reset contents, range edges, unused action, control characters
    send_request(ACT_READ, 8'h00, 5'd0, 7'd0);
    send_request(ACT_READ, 8'hFF, 5'(NROWS - 1), 7'(NCOLS - 1));
    send_request(ACT_READ, 8'h00, 5'(NROWS), 7'd0);
    send_request(ACT_READ, 8'h00, 5'd0, 7'(NCOLS));
    send_request(ACT_READ, 8'hFF, 5'h1F, 7'h7F);
    send_request(2'd3, 8'hFF, 5'h1F, 7'h7F);
    send_request(ACT_PUT, 8'h41, 5'h1F, 7'h7F);
    send_request(ACT_PUT, 8'h00, 5'd0, 7'd0);
    send_request(ACT_PUT, 8'hFF, 5'd0, 7'd0);
    send_request(ACT_PUT, RETURN_CHAR, 5'd0, 7'd0);
    send_request(ACT_PUT, 8'h7E, 5'd0, 7'd0);
    send_request(ACT_PUT, NEWLINE_CHAR, 5'd0, 7'd0);
    send_request(ACT_READ, 8'h00, 5'd0, 7'd0);
    send_request(ACT_READ, 8'h00, 5'd0, 7'd1);
    send_request(ACT_CLEAR, 8'h00, 5'd0, 7'd0);
    send_request(ACT_READ, 8'h00, 5'd0, 7'd0);
    drain();
    set_colors(4'hF, 4'hF);
    send_request(ACT_PUT, 8'h5A, 5'd0, 7'd0);
    send_request(ACT_READ, 8'h00, 5'd0, 7'd0);
    send_request(ACT_CLEAR, 8'h00, 5'd0, 7'd0);
    send_request(ACT_READ, 8'h00, 5'(NROWS - 1), 7'(NCOLS - 1));
    drain();
    set_colors(4'h0, 4'h0);
    send_request(ACT_PUT, 8'h41, 5'd0, 7'd0);
    send_request(ACT_READ, 8'h00, 5'd0, 7'd0);

    // Random phases: no idling, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: set_colors(4'h0, 4'hF);
        1: set_colors(4'hF, 4'h0);
        default: set_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
      endcase
      sender_idle_pct    = (phase == 1) ? 82 : (phase == 3) ? 36 : 0;
      receiver_stall_pct = (phase == 2) ? 82 : (phase == 3) ? 36 : 0;
      phase_start = requests_sent;
      paused = 1'b0;
      while (requests_sent - phase_start < PHASE_ITEMS) begin
        send_burst();
        // Pause once mid-phase until all results are in, then recolor
        if (!paused && requests_sent - phase_start >= PHASE_ITEMS / 2) begin
          drain();
          set_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d reads, %0d clears, %0d scrolls, %0d color settings.",
             requests_sent, sb.n_reads, sb.n_clears, sb.n_scrolls, color_settings);
    $display("Checked %0d results with %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.reports_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
